### sv/llf_pkg.sv
package llf_pkg;

  localparam int ENTRIES_DEF    = 4;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 64;

  typedef enum logic [0:0] {
    KIND_LOOKUP = 1'b0,
    KIND_FILL   = 1'b1
  } kind_t;

  // status of one processed word
  typedef struct packed {
    logic hit;
    logic evicted;
  } res_flags_t;

endpackage

### sv/lru_cache_lookup_fill_core.sv
// Fully associative LRU cache, one lookup or fill per word.
//
// Input channel (in_valid/in_ready): kind selects lookup or fill of key;
// fill_data is stored on a fill. Output channel (out_valid/out_ready):
// one result word per input word, in order: hit, read_data, evicted.
//
// A word accepted at the input sits in the input register and is loaded into
// the result register once that register is empty or its word is being taken
// (advance). All tag compares, victim choice and recency update are done in
// parallel as the word moves between the two registers, so one word per
// cycle is sustained while the receiver takes results.
//
// When out_ready is low the result register holds its word; the input
// register still holds one more word, after which in_ready drops.
//
// Reset (rst, synchronous) empties the cache and both registers; stored
// keys and data are not cleared, only the valid bits and ranks.
module lru_cache_lookup_fill_core #(
  parameter int ENTRIES    = llf_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH  = llf_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = llf_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [KEY_WIDTH-1:0]  key,
  input  logic [DATA_WIDTH-1:0] fill_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic                  evicted
);

  logic                  q_valid;
  logic                  q_kind;
  logic [KEY_WIDTH-1:0]  q_key;
  logic [DATA_WIDTH-1:0] q_data;
  logic                  advance;
  llf_pkg::res_flags_t   flags;
  logic [DATA_WIDTH-1:0] rdata;

  assign advance = q_valid && (!out_valid || out_ready);

  llf_in_reg #(
    .KEY_WIDTH (KEY_WIDTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .key      (key),
    .fill_data(fill_data),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_kind   (q_kind),
    .q_key    (q_key),
    .q_data   (q_data)
  );

  llf_store #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .kind (q_kind),
    .key  (q_key),
    .data (q_data),
    .flags(flags),
    .rdata(rdata)
  );

  llf_out_reg #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .d_flags  (flags),
    .d_rdata  (rdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit      (hit),
    .read_data(read_data),
    .evicted  (evicted)
  );

endmodule

### sv/llf_in_reg.sv
module llf_in_reg #(
  parameter int KEY_WIDTH  = llf_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = llf_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [KEY_WIDTH-1:0]  key,
  input  logic [DATA_WIDTH-1:0] fill_data,
  input  logic                  advance,
  output logic                  q_valid,
  output logic                  q_kind,
  output logic [KEY_WIDTH-1:0]  q_key,
  output logic [DATA_WIDTH-1:0] q_data
);

  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_kind <= kind;
      q_key  <= key;
      q_data <= fill_data;
    end
  end

endmodule

### sv/llf_store.sv
module llf_store #(
  parameter int ENTRIES    = llf_pkg::ENTRIES_DEF,
  parameter int KEY_WIDTH  = llf_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = llf_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic                   kind,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [DATA_WIDTH-1:0]  data,
  output llf_pkg::res_flags_t    flags,
  output logic [DATA_WIDTH-1:0]  rdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] OLDEST = IDX_W'(ENTRIES - 1);

  logic [ENTRIES-1:0]    entry_valid;
  logic [KEY_WIDTH-1:0]  entry_key  [ENTRIES];
  logic [DATA_WIDTH-1:0] entry_data [ENTRIES];
  logic [IDX_W-1:0]      rank       [ENTRIES];

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] age;
  logic               found;
  logic               full;
  logic               is_fill;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   slot;

  assign is_fill = (kind == llf_pkg::KIND_FILL);
  assign full    = &entry_valid;

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_key[i] == key);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
      end
      // ranks of a full set are a permutation, so the oldest is unique
      if (entry_valid[i] && rank[i] == OLDEST) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  assign found = |match;

  always_comb begin
    priority if (found) begin
      slot = hit_idx;
    end else if (full) begin
      slot = victim_idx;
    end else begin
      slot = free_idx;
    end
  end

  // entries younger than the touched one age by one; a new entry ages all other valid ones
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age[i] = entry_valid[i] && (IDX_W'(i) != slot) &&
               (!found || rank[i] < rank[hit_idx]);
    end
  end

  assign flags.hit     = found;
  assign flags.evicted = is_fill && !found && full;
  assign rdata         = (found && !is_fill) ? entry_data[hit_idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (go && (found || is_fill)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank[i] <= '0;
        end else if (age[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      if (is_fill) begin
        entry_valid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_fill) begin
      entry_key[slot]  <= key;
      entry_data[slot] <= data;
    end
  end

endmodule

### sv/llf_out_reg.sv
module llf_out_reg #(
  parameter int DATA_WIDTH = llf_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  llf_pkg::res_flags_t   d_flags,
  input  logic [DATA_WIDTH-1:0] d_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic                  evicted
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit       <= d_flags.hit;
      evicted   <= d_flags.evicted;
      read_data <= d_rdata;
    end
  end

endmodule
